@@ design/dtpy_pkg.sv @@
`default_nettype none

package dtpy_pkg;

  // Angles inside the CORDIC kernels are degrees with 28 fraction bits.
  localparam int unsigned ACC_FRAC = 28;
  localparam int unsigned ACC_W    = 38;

  localparam int unsigned PITCH_W = 24;
  localparam int unsigned YAW_W   = 25;

  localparam int unsigned PROD_W = 62;
  localparam int unsigned SUM_W  = 64;

  localparam logic signed [ACC_W-1:0] HALF_TURN_Q  = 38'sd48318382080;
  localparam logic [63:0]             RAD_IN_DEG_Q = 64'd15380218700;
  localparam logic [29:0]             INV_GAIN_Q30 = 30'd652032875;

  localparam logic [63:0] ATAN_HEAD [17] = '{
    64'd12079595520, 64'd7131001626, 64'd3767825416, 64'd1912607013,
    64'd960014949,   64'd480475470,  64'd240296363,  64'd120155514,
    64'd60078674,    64'd30039451,   64'd15019740,   64'd7509872,
    64'd3754936,     64'd1877468,    64'd938734,     64'd469367,
    64'd234684
  };

  // Arctangent of 2^-i in Q28 degrees. Beyond the stored head the angle is
  // close enough to 2^-i radians to be taken from the radian constant.
  function automatic logic signed [ACC_W-1:0] atan_q(input logic [4:0] i);
    logic [63:0] t;
    if (i < 5'd17) begin
      t = ATAN_HEAD[i];
    end else begin
      t = (RAD_IN_DEG_Q + (64'd1 << (i - 5'd1))) >> i;
    end
    return t[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/dtpy_vec_if.sv @@
`default_nettype none

interface dtpy_vec_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vec_x;
  logic signed [COORD_WIDTH-1:0] vec_y;
  logic signed [COORD_WIDTH-1:0] vec_z;

  modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

`default_nettype wire

@@ design/dtpy_ang_if.sv @@
`default_nettype none

interface dtpy_ang_if
  import dtpy_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [PITCH_W-1:0] pitch_deg;
  logic signed [YAW_W-1:0]   yaw_deg;

  modport source (output valid, output pitch_deg, output yaw_deg, input ready);
  modport sink   (input valid, input pitch_deg, input yaw_deg, output ready);
endinterface

`default_nettype wire

@@ design/direction_to_pitch_yaw.sv @@
// View angles of a 3-D direction vector.
// Input channel vec_i carries one vector (vec_x, vec_y, vec_z) in signed Q16.16
// per beat. Output channel ang_o carries one beat per vector: yaw_deg is
// atan2(y, x) and pitch_deg is the negated atan2(z, sqrt(x*x + y*y)), both in
// degrees scaled by 2^ANGLE_FRAC_BITS; the zero vector gives zero angles.
// Two vectoring CORDIC kernels of CORDIC_STAGES stages each run one after the
// other, one iteration per register stage, with a two-stage multiply for the
// gain correction of the planar length between them.
// A new vector is accepted in every cycle in which vec_i.ready is high, so the
// sustained rate is one vector per cycle while the output does not stall.
// Reset clears the valid bits of every stage and the output buffer; no beat
// is shown until one has been accepted. When the receiver stalls, the result
// holds on ang_o and the pipeline still moves until one more result sits in
// the skid register; only then does vec_i.ready drop, and it rises again in
// the cycle after the stalled beat is taken.

`default_nettype none

module direction_to_pitch_yaw
  import dtpy_pkg::*;
#(
  parameter int unsigned COORD_WIDTH     = 32,
  parameter int unsigned ANGLE_FRAC_BITS = 16,
  parameter int unsigned CORDIC_STAGES   = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dtpy_vec_if.sink    vec_i,
  dtpy_ang_if.source  ang_o
);

  localparam int unsigned DATA_W    = COORD_WIDTH + 3;
  localparam int unsigned RND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND_HALF  = ACC_W'(64'd1 << (RND_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] YAW_LIM   = ACC_W'(64'd180 << ANGLE_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] PITCH_LIM = ACC_W'(64'd90 << ANGLE_FRAC_BITS);

  logic en;
  logic pop;
  logic push;

  // First kernel: yaw and the gain-scaled planar length.
  logic                          k1_valid;
  logic signed [ACC_W-1:0]       k1_angle;
  logic signed [DATA_W-1:0]      k1_mag;
  logic [COORD_WIDTH-1:0]        k1_z;

  logic [SUM_W-1:0]              m_ext;
  logic                          v_p1_q;
  logic [PROD_W-1:0]             p_hi_q;
  logic [PROD_W-1:0]             p_lo_q;
  logic [COORD_WIDTH-1:0]        z_p1_q;
  logic signed [ACC_W-1:0]       yaw_p1_q;

  logic [SUM_W-1:0]              r_sum;
  logic                          v_p2_q;
  logic signed [DATA_W-1:0]      r_p2_q;
  logic [COORD_WIDTH-1:0]        z_p2_q;
  logic signed [ACC_W-1:0]       yaw_p2_q;

  // Second kernel: elevation over the planar length.
  logic                          k2_valid;
  logic signed [ACC_W-1:0]       k2_angle;
  logic signed [ACC_W-1:0]       k2_yaw;

  logic                          v_r1_q;
  logic signed [ACC_W-1:0]       yaw_r1_q;
  logic signed [ACC_W-1:0]       pitch_r1_q;

  logic signed [ACC_W-1:0]       pitch_neg;
  logic signed [ACC_W-1:0]       yaw_c;
  logic signed [ACC_W-1:0]       pitch_c;
  logic                          v_r2_q;
  logic signed [YAW_W-1:0]       yaw_r2_q;
  logic signed [PITCH_W-1:0]     pitch_r2_q;

  logic                          out_valid_q;
  logic signed [YAW_W-1:0]       out_yaw_q;
  logic signed [PITCH_W-1:0]     out_pitch_q;
  logic                          skid_valid_q;
  logic signed [YAW_W-1:0]       skid_yaw_q;
  logic signed [PITCH_W-1:0]     skid_pitch_q;

  // The whole pipeline moves together; it stops only once the skid register
  // holds a result behind a stalled output beat.
  assign en          = !skid_valid_q;
  assign vec_i.ready = en;

  dtpy_cordic #(
    .DATA_W (DATA_W),
    .STAGES (CORDIC_STAGES),
    .SIDE_W (COORD_WIDTH)
  ) u_yaw_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vec_i.valid),
    .a_i     (DATA_W'($signed(vec_i.vec_x))),
    .b_i     (DATA_W'($signed(vec_i.vec_y))),
    .side_i  (vec_i.vec_z),
    .valid_o (k1_valid),
    .angle_o (k1_angle),
    .mag_o   (k1_mag),
    .side_o  (k1_z)
  );

  // The length is split at bit 32 so that each product stays near 32 by 30
  // bits; the low product alone is truncated, as the high one is exact.
  assign m_ext = SUM_W'($unsigned(k1_mag));
  assign r_sum = (SUM_W'(p_hi_q) << 2) + SUM_W'(p_lo_q >> 30);

  dtpy_cordic #(
    .DATA_W (DATA_W),
    .STAGES (CORDIC_STAGES),
    .SIDE_W (ACC_W)
  ) u_pitch_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_p2_q),
    .a_i     (r_p2_q),
    .b_i     (DATA_W'($signed(z_p2_q))),
    .side_i  (yaw_p2_q),
    .valid_o (k2_valid),
    .angle_o (k2_angle),
    .mag_o   (),
    .side_o  (k2_yaw)
  );

  always_comb begin
    pitch_neg = -pitch_r1_q;
    if (yaw_r1_q > YAW_LIM) begin
      yaw_c = YAW_LIM;
    end else if (yaw_r1_q < -YAW_LIM) begin
      yaw_c = -YAW_LIM;
    end else begin
      yaw_c = yaw_r1_q;
    end
    if (pitch_neg > PITCH_LIM) begin
      pitch_c = PITCH_LIM;
    end else if (pitch_neg < -PITCH_LIM) begin
      pitch_c = -PITCH_LIM;
    end else begin
      pitch_c = pitch_neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_p1_q <= 1'b0;
      v_p2_q <= 1'b0;
      v_r1_q <= 1'b0;
      v_r2_q <= 1'b0;
    end else if (en) begin
      v_p1_q <= k1_valid;
      v_p2_q <= v_p1_q;
      v_r1_q <= k2_valid;
      v_r2_q <= v_r1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_hi_q     <= PROD_W'(m_ext[63:32]) * PROD_W'(INV_GAIN_Q30);
      p_lo_q     <= PROD_W'(m_ext[31:0]) * PROD_W'(INV_GAIN_Q30);
      z_p1_q     <= k1_z;
      yaw_p1_q   <= k1_angle;
      r_p2_q     <= r_sum[DATA_W-1:0];
      z_p2_q     <= z_p1_q;
      yaw_p2_q   <= yaw_p1_q;
      yaw_r1_q   <= (k2_yaw + RND_HALF) >>> RND_SHIFT;
      pitch_r1_q <= (k2_angle + RND_HALF) >>> RND_SHIFT;
      yaw_r2_q   <= yaw_c[YAW_W-1:0];
      pitch_r2_q <= pitch_c[PITCH_W-1:0];
    end
  end

  // Output register with one skid entry behind it.
  assign pop  = out_valid_q && ang_o.ready;
  assign push = en && v_r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_yaw_q   <= skid_yaw_q;
        out_pitch_q <= skid_pitch_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_yaw_q   <= yaw_r2_q;
        skid_pitch_q <= pitch_r2_q;
      end else begin
        out_yaw_q   <= yaw_r2_q;
        out_pitch_q <= pitch_r2_q;
      end
    end
  end

  assign ang_o.valid     = out_valid_q;
  assign ang_o.yaw_deg   = out_yaw_q;
  assign ang_o.pitch_deg = out_pitch_q;

endmodule

`default_nettype wire

@@ design/dtpy_cordic.sv @@
`default_nettype none

module dtpy_cordic
  import dtpy_pkg::*;
#(
  parameter int unsigned DATA_W = 35,
  parameter int unsigned STAGES = 24,
  parameter int unsigned SIDE_W = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     valid_o,
  output logic signed [ACC_W-1:0]  angle_o,
  output logic signed [DATA_W-1:0] mag_o,
  output logic [SIDE_W-1:0]        side_o
);

  logic                     pre_neg;
  logic                     pre_zero;
  logic signed [DATA_W-1:0] pre_a;
  logic signed [DATA_W-1:0] pre_b;
  logic signed [ACC_W-1:0]  pre_acc;

  logic [STAGES:0]          v_q;
  logic [STAGES:0]          zero_q;
  logic signed [DATA_W-1:0] a_q   [STAGES+1];
  logic signed [DATA_W-1:0] b_q   [STAGES+1];
  logic signed [ACC_W-1:0]  acc_q [STAGES+1];
  logic [SIDE_W-1:0]        s_q   [STAGES+1];

  logic signed [DATA_W-1:0] a_d   [STAGES];
  logic signed [DATA_W-1:0] b_d   [STAGES];
  logic signed [ACC_W-1:0]  acc_d [STAGES];

  // A vector in the left half-plane is turned by half a turn first, so the
  // iterations only have to cover the right half-plane.
  assign pre_neg  = a_i[DATA_W-1];
  assign pre_zero = (a_i == '0) && (b_i == '0);
  assign pre_a    = pre_neg ? -a_i : a_i;
  assign pre_b    = pre_neg ? -b_i : b_i;
  assign pre_acc  = !pre_neg ? '0 : (b_i[DATA_W-1] ? -HALF_TURN_Q : HALF_TURN_Q);

  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      if (!b_q[k][DATA_W-1]) begin
        a_d[k]   = a_q[k] + (b_q[k] >>> k);
        b_d[k]   = b_q[k] - (a_q[k] >>> k);
        acc_d[k] = acc_q[k] + atan_q(5'(k));
      end else begin
        a_d[k]   = a_q[k] - (b_q[k] >>> k);
        b_d[k]   = b_q[k] + (a_q[k] >>> k);
        acc_d[k] = acc_q[k] - atan_q(5'(k));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STAGES-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q   <= {zero_q[STAGES-1:0], pre_zero};
      a_q[0]   <= pre_a;
      b_q[0]   <= pre_b;
      acc_q[0] <= pre_acc;
      s_q[0]   <= side_i;
      for (int k = 0; k < STAGES; k++) begin
        a_q[k+1]   <= a_d[k];
        b_q[k+1]   <= b_d[k];
        acc_q[k+1] <= acc_d[k];
        s_q[k+1]   <= s_q[k];
      end
    end
  end

  // The zero vector has no direction; its angle is defined as zero.
  assign valid_o = v_q[STAGES];
  assign angle_o = zero_q[STAGES] ? '0 : acc_q[STAGES];
  assign mag_o   = a_q[STAGES];
  assign side_o  = s_q[STAGES];

endmodule

`default_nettype wire

@@ design/dtpy_checker.sv @@
`default_nettype none

module dtpy_checker
  import dtpy_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = 16
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [PITCH_W-1:0] pitch_deg_i,
  input logic signed [YAW_W-1:0]   yaw_deg_i
);

  localparam longint YAW_LIM   = longint'(180) << ANGLE_FRAC_BITS;
  localparam longint PITCH_LIM = longint'(90) << ANGLE_FRAC_BITS;

  logic [15:0] pending_q;

  // Beats accepted at the input and not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 16'(in_valid_i && in_ready_i)
                             - 16'(out_valid_i && out_ready_i);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(pitch_deg_i) && $stable(yaw_deg_i))
    else $error("stalled result beat changed");

  a_ready_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_i && !out_ready_i) |=> in_ready_i)
    else $error("input held off without a stalled output");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 16'd0)
    else $error("result beat without an accepted input");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (ANGLE_FRAC_BITS > 16) ||
      ((longint'(yaw_deg_i) <= YAW_LIM) && (longint'(yaw_deg_i) >= -YAW_LIM) &&
       (longint'(pitch_deg_i) <= PITCH_LIM) && (longint'(pitch_deg_i) >= -PITCH_LIM)))
    else $error("angle beyond its saturation limit");

endmodule

bind direction_to_pitch_yaw dtpy_checker #(
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_dtpy_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (vec_i.valid),
  .in_ready_i  (vec_i.ready),
  .out_valid_i (ang_o.valid),
  .out_ready_i (ang_o.ready),
  .pitch_deg_i (ang_o.pitch_deg),
  .yaw_deg_i   (ang_o.yaw_deg)
);

`default_nettype wire
